### design/wpm_pkg.sv
// Shared types and constants for the wildcard pattern matcher.
// No dependencies; used by wpm_cell and wildcard_pattern_match_top.
`default_nettype none

package wpm_pkg;

    // Default pattern capacity in symbols
    localparam int MAX_PATTERN_DEF = 64;

    // Wildcard symbols
    localparam logic [7:0] STAR_SYM  = 8'd42;
    localparam logic [7:0] QUERY_SYM = 8'd63;

    // Item mode codes; code 3 is unused and leaves the state alone
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_FEED   = 2'd2;

    // Input beat
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] symbol;
    } item_t;

    // Output beat
    typedef struct packed {
        logic matched;
        logic overflow;
    } result_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic en;    // cell lies inside the stored pattern
        logic feed;  // 1: text update, 0: rebuild row for empty text
        logic wr;    // load the appended pattern symbol
    } cell_ctrl_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } state_t;

endpackage

`default_nettype wire

### design/wildcard_pattern_match_top.sv
// Top level of the wildcard pattern matcher: sequencer plus a row of wpm_cell.
// Depends on wpm_pkg and wpm_cell.
`default_nettype none

// Usage:
//   Input channel item/item_valid/item_stall carries one beat per item:
//   mode 0 clears the pattern, mode 1 appends a pattern symbol, mode 2 feeds
//   a text symbol. Output channel result/result_valid/result_stall returns one
//   beat per item: whether the text so far matches the whole pattern, and an
//   overflow flag for an append dropped because the store is full.
//   Clear, unused mode 3, and text beats while the pattern is empty load the
//   result register directly. Append and text beats send a token down the
//   row of cells, one cell per cycle, since a '*' cell needs its left
//   neighbor's new bit; the result is registered when the token reaches cell
//   L (pattern length after the item); the next beat is accepted in the cycle the result shows.
//   While result_stall holds, the result stays in the output register and
//   item_stall is raised; a beat is taken as soon as the result drains.
//   Reset empties the pattern and sets the row to the empty-text state; the
//   pattern symbols themselves are not cleared.
module wildcard_pattern_match_top
    import wpm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire item_t   item,
    input  wire logic    item_valid,
    output logic         item_stall,
    output result_t      result,
    output logic         result_valid,
    input  wire logic    result_stall
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    state_t            state_reg;
    state_t            state_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic              row0_reg;
    logic              row0_next;
    logic              tok0_reg;
    logic              tok0_next;
    logic              diag0_reg;
    logic              diag0_next;
    logic              feed_reg;
    logic              feed_next;
    logic [7:0]        text_reg;
    logic [7:0]        text_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_data_reg;
    result_t           out_data_next;

    logic              accept;
    logic              append_ok;
    logic              wave_start;
    logic              done;

    logic [MAX_PATTERN:0] tok_vec;
    logic [MAX_PATTERN:0] row_vec;
    logic [MAX_PATTERN:0] diag_vec;

    assign tok_vec[0]  = tok0_reg;
    assign row_vec[0]  = row0_reg;
    assign diag_vec[0] = diag0_reg;

    // Row of cells, token passes left to right
    genvar j;
    generate
        for (j = 1; j <= MAX_PATTERN; j++)
        begin : g_cell
            cell_ctrl_t ctrl;
            always_comb
            begin
                ctrl.en   = (len_reg >= LEN_W'(j));
                ctrl.feed = feed_reg;
                ctrl.wr   = append_ok && (len_reg == LEN_W'(j - 1));
            end

            wpm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .wr_data  (item.symbol),
                .text_sym (text_reg),
                .tok_in   (tok_vec[j-1]),
                .new_in   (row_vec[j-1]),
                .diag_in  (diag_vec[j-1]),
                .tok      (tok_vec[j]),
                .row      (row_vec[j]),
                .diag     (diag_vec[j])
            );
        end
    endgenerate

    // Handshake and sweep control
    always_comb
    begin
        item_stall = (state_reg != ST_IDLE) || (out_valid_reg && result_stall);
        accept     = item_valid && !item_stall;
        append_ok  = accept && (item.mode == MODE_APPEND)
                     && (len_reg < LEN_W'(MAX_PATTERN));
        wave_start = accept && ((item.mode == MODE_APPEND)
                     || ((item.mode == MODE_FEED) && (len_reg != '0)));
        done       = (state_reg == ST_SWEEP) && tok_vec[len_reg];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (wave_start)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and result register next values
    always_comb
    begin
        len_next       = len_reg;
        row0_next      = row0_reg;
        tok0_next      = 1'b0;
        diag0_next     = diag0_reg;
        feed_next      = feed_reg;
        text_next      = text_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_data_next  = out_data_reg;

        if (accept)
        begin
            case (item.mode)
                MODE_CLEAR:
                begin
                    len_next               = '0;
                    row0_next              = 1'b1;
                    out_valid_next         = 1'b1;
                    out_data_next.matched  = 1'b1;
                    out_data_next.overflow = 1'b0;
                end
                MODE_APPEND:
                begin
                    if (len_reg < LEN_W'(MAX_PATTERN))
                    begin
                        len_next = len_reg + LEN_W'(1);
                        ovf_next = 1'b0;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    row0_next  = 1'b1;
                    tok0_next  = 1'b1;
                    diag0_next = row0_reg;
                    feed_next  = 1'b0;
                end
                MODE_FEED:
                begin
                    row0_next  = 1'b0;
                    diag0_next = row0_reg;
                    text_next  = item.symbol;
                    feed_next  = 1'b1;
                    ovf_next   = 1'b0;
                    if (len_reg != '0)
                    begin
                        tok0_next = 1'b1;
                    end
                    else
                    begin
                        out_valid_next         = 1'b1;
                        out_data_next.matched  = 1'b0;
                        out_data_next.overflow = 1'b0;
                    end
                end
                default:
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.matched  = row_vec[len_reg];
                    out_data_next.overflow = 1'b0;
                end
            endcase
        end

        if (done)
        begin
            out_valid_next         = 1'b1;
            out_data_next.matched  = row_vec[len_reg];
            out_data_next.overflow = ovf_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            row0_reg      <= 1'b1;
            tok0_reg      <= 1'b0;
            diag0_reg     <= 1'b0;
            feed_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            row0_reg      <= row0_next;
            tok0_reg      <= tok0_next;
            diag0_reg     <= diag0_next;
            feed_reg      <= feed_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        text_reg     <= text_next;
        out_data_reg <= out_data_next;
    end

    assign result       = out_data_reg;
    assign result_valid = out_valid_reg;

endmodule

`default_nettype wire

### design/wpm_cell.sv
// One pattern position of the matcher row: holds its pattern symbol and row bit.
// Depends on wpm_pkg. A token from the left neighbor triggers one update.
`default_nettype none

module wpm_cell
    import wpm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire logic [7:0] wr_data,
    input  wire logic [7:0] text_sym,
    input  wire logic       tok_in,
    input  wire logic       new_in,   // updated row bit of left neighbor
    input  wire logic       diag_in,  // old row bit of left neighbor
    output logic            tok,
    output logic            row,
    output logic            diag
);

    logic [7:0] pat_reg;
    logic       row_reg;
    logic       row_next;
    logic       tok_reg;
    logic       tok_next;
    logic       diag_reg;
    logic       diag_next;
    logic       hit;
    logic       cell_val;

    // Pattern symbol, no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
        begin
            pat_reg <= wr_data;
        end
    end

    // Cell update: for text, literal or '?' first, then '*'; else empty-text rebuild
    always_comb
    begin
        hit = tok_in & ctrl.en;
        if (ctrl.feed)
        begin
            if ((text_sym == pat_reg) || (pat_reg == QUERY_SYM))
            begin
                cell_val = diag_in;
            end
            else if (pat_reg == STAR_SYM)
            begin
                cell_val = row_reg | new_in;
            end
            else
            begin
                cell_val = 1'b0;
            end
        end
        else
        begin
            cell_val = new_in & (pat_reg == STAR_SYM);
        end
        row_next  = hit ? cell_val : row_reg;
        diag_next = hit ? row_reg : diag_reg;
        tok_next  = hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= 1'b0;
            tok_reg  <= 1'b0;
            diag_reg <= 1'b0;
        end
        else
        begin
            row_reg  <= row_next;
            tok_reg  <= tok_next;
            diag_reg <= diag_next;
        end
    end

    assign tok  = tok_reg;
    assign row  = row_reg;
    assign diag = diag_reg;

endmodule

`default_nettype wire

### bench/wildcard_pattern_match_top_tb.sv
// Self-checking testbench for wildcard_pattern_match_top: directed and random beats,
// checked against a row-at-a-time predictor. Depends on wpm_pkg and the design.
`default_nettype none

module wildcard_pattern_match_top_tb;
    import wpm_pkg::*;

    localparam int CAP = MAX_PATTERN_DEF;
    // Worst case: token runs the full row, plus margin
    localparam int SETTLE_CYCLES = CAP + 16;
    localparam int RANDOM_ITEMS = 260;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_X = 8'h78;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    item_t   item = '0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    result_t result;
    logic    result_valid;
    logic    result_stall = 1'b0;

    wildcard_pattern_match_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor state: stored pattern, its length, and the match row
    logic [7:0]   pat_mem [CAP];
    int           pat_len = 0;
    logic [CAP:0] match_bits = 1;

    result_t pending_results [$];
    result_t head;
    int      mismatch_count = 0;
    int      items_sent = 0;
    bit      idle_on = 1'b1;
    bit      valid_hi = 1'b0;
    int      stall_left = 0;

    // Row for the empty text: entry j set only while the prefix is all stars
    function automatic void rebuild_row();
        match_bits = '0;
        match_bits[0] = 1'b1;
        for (int j = 1; j <= pat_len; j++)
            match_bits[j] = match_bits[j - 1] && (pat_mem[j - 1] == STAR_SYM);
    endfunction

    // Advance the predictor by one beat and return the expected result
    function automatic result_t predict_match(item_t it);
        result_t    r;
        logic       diag;
        logic       above;
        logic       next_bit;
        logic [7:0] p;
        r.overflow = 1'b0;
        case (it.mode)
            MODE_CLEAR:
            begin
                pat_len = 0;
                rebuild_row();
            end
            MODE_APPEND:
            begin
                if (pat_len < CAP)
                begin
                    pat_mem[pat_len] = it.symbol;
                    pat_len++;
                end
                else
                    r.overflow = 1'b1;
                rebuild_row();
            end
            MODE_FEED:
            begin
                // literal or '?' test comes before the '*' test
                diag = match_bits[0];
                match_bits[0] = 1'b0;
                for (int j = 1; j <= pat_len; j++)
                begin
                    p = pat_mem[j - 1];
                    above = match_bits[j];
                    if (it.symbol == p || p == QUERY_SYM)
                        next_bit = diag;
                    else if (p == STAR_SYM)
                        next_bit = above | match_bits[j - 1];
                    else
                        next_bit = 1'b0;
                    diag = above;
                    match_bits[j] = next_bit;
                end
            end
            default: ;
        endcase
        r.matched = match_bits[pat_len];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_pattern_symbol();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return STAR_SYM;
        else if (r < 40)
            return QUERY_SYM;
        else if (r < 85)
            return r[0] ? CH_A : CH_B;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_text_symbol();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return r[0] ? CH_A : CH_B;
        else if (r < 80)
            return r[0] ? STAR_SYM : QUERY_SYM;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // Send one beat; an optional gap goes in front of it
    task automatic send_beat(input logic [1:0] mode, input logic [7:0] symbol);
        int    gap;
        item_t it;
        it.mode = mode;
        it.symbol = symbol;
        gap = pick_gap();
        if (gap > 0)
        begin
            if (valid_hi)
                item_valid <= 1'b0;
            valid_hi = 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= it;
        if (!valid_hi)
            item_valid <= 1'b1;
        valid_hi = 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        pending_results.push_back(predict_match(it));
        items_sent++;
    endtask

    task automatic stop_input();
        if (valid_hi)
            item_valid <= 1'b0;
        valid_hi = 1'b0;
    endtask

    task automatic wait_results();
        stop_input();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver stall: mostly short, now and then long
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 99) < 25)
        begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // Result checker: each accepted beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
                flag_error($sformatf("result beat with nothing expected: matched=%b overflow=%b",
                                     result.matched, result.overflow));
            else
            begin
                head = pending_results.pop_front();
                if (result.matched !== head.matched)
                    flag_error($sformatf("matched expected %b got %b",
                                         head.matched, result.matched));
                if (result.overflow !== head.overflow)
                    flag_error($sformatf("overflow expected %b got %b",
                                         head.overflow, result.overflow));
            end
        end
    end

    // Empty pattern, literal matches, symbol extremes, unused mode
    task automatic test_basic_items();
        send_beat(MODE_CLEAR, 8'h00);
        send_beat(MODE_FEED, 8'h00);
        send_beat(MODE_UNUSED, 8'hFF);
        send_beat(MODE_CLEAR, 8'hFF);
        send_beat(MODE_APPEND, CH_A);
        send_beat(MODE_FEED, CH_A);
        send_beat(MODE_FEED, CH_A);
        send_beat(MODE_APPEND, 8'h00);
        send_beat(MODE_APPEND, 8'hFF);
        send_beat(MODE_FEED, CH_A);
        send_beat(MODE_FEED, 8'h00);
        send_beat(MODE_FEED, 8'hFF);
        stop_input();
    endtask

    // Star and query in the pattern, and as literal text symbols
    task automatic test_wildcards();
        send_beat(MODE_CLEAR, 8'h55);
        send_beat(MODE_APPEND, STAR_SYM);
        send_beat(MODE_APPEND, QUERY_SYM);
        send_beat(MODE_APPEND, STAR_SYM);
        send_beat(MODE_FEED, STAR_SYM);
        send_beat(MODE_FEED, QUERY_SYM);
        send_beat(MODE_FEED, CH_X);
        send_beat(MODE_UNUSED, 8'h5A);
        send_beat(MODE_CLEAR, 8'hAA);
        send_beat(MODE_APPEND, QUERY_SYM);
        send_beat(MODE_FEED, STAR_SYM);
        send_beat(MODE_FEED, QUERY_SYM);
        stop_input();
    endtask

    // Fill the store, then appends beyond capacity are dropped
    task automatic test_full_store();
        send_beat(MODE_CLEAR, 8'h00);
        for (int k = 0; k < CAP; k++)
            send_beat(MODE_APPEND, (k % 8 == 5) ? QUERY_SYM : STAR_SYM);
        send_beat(MODE_APPEND, CH_A);
        send_beat(MODE_APPEND, CH_B);
        send_beat(MODE_FEED, CH_A);
        send_beat(MODE_FEED, 8'hFF);
        send_beat(MODE_UNUSED, 8'h00);
        send_beat(MODE_FEED, 8'h00);
        stop_input();
    endtask

    // One random sequence: optional clear, appends, then text shaped from the pattern
    task automatic run_sequence();
        int         plen;
        int         k;
        logic [7:0] txt [$];
        if ($urandom_range(0, 4) != 0)
            send_beat(MODE_CLEAR, 8'($urandom_range(0, 255)));
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 8);
        repeat (plen) send_beat(MODE_APPEND, pick_pattern_symbol());
        for (k = 0; k < pat_len; k++)
        begin
            if (pat_mem[k] == STAR_SYM)
                repeat ($urandom_range(0, 3)) txt.push_back(pick_text_symbol());
            else if (pat_mem[k] == QUERY_SYM)
                txt.push_back(pick_text_symbol());
            else
                txt.push_back(pat_mem[k]);
        end
        // Break some texts so misses are well represented
        if ($urandom_range(0, 2) == 0 && txt.size() > 0)
        begin
            k = $urandom_range(0, txt.size() - 1);
            case ($urandom_range(0, 2))
                0: txt[k] = pick_text_symbol();
                1: txt.delete(k);
                default: txt.insert(k, pick_text_symbol());
            endcase
        end
        foreach (txt[i])
            send_beat(MODE_FEED, txt[i]);
        repeat ($urandom_range(0, 2)) send_beat(MODE_FEED, pick_text_symbol());
    endtask

    // Mostly well-formed sequences, some random noise beats
    task automatic test_random_sequences(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 99) < 8)
                send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            else
                run_sequence();
        end
        stop_input();
    endtask

    // No idling on either side, then the sender waits for every result; then more sequences with idling
    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (3) run_sequence();
        wait_results();
        idle_on = 1'b1;
        repeat (3) run_sequence();
        stop_input();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_items();
        test_wildcards();
        test_full_store();
        test_back_to_back();
        test_random_sequences(RANDOM_ITEMS);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
